[hw/rtl/p1305_pkg.sv]
// Package with shared types and constants for the Poly1305 core.
`default_nettype none
package p1305_pkg;

    localparam int unsigned LimbW   = 26;
    localparam int unsigned AccW    = 27;
    localparam int unsigned NumLimb = 5;

    localparam logic [25:0] LimbMask = 26'h3ffffff;
    localparam logic [25:0] Clamp1   = 26'h3ffff03;
    localparam logic [25:0] Clamp2   = 26'h3ffc0ff;
    localparam logic [25:0] Clamp3   = 26'h3f03fff;
    localparam logic [25:0] Clamp4   = 26'h00fffff;

    localparam logic [1:0] RegRLow  = 2'd0;
    localparam logic [1:0] RegRHigh = 2'd1;
    localparam logic [1:0] RegSLow  = 2'd2;
    localparam logic [1:0] RegSHigh = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL,
        ST_CARRY,
        ST_FINAL,
        ST_TAG,
        ST_OUT
    } state_t;

    typedef logic [AccW-1:0] limb_t;

endpackage : p1305_pkg
`default_nettype wire

[hw/rtl/p1305_mac_unit.sv]
// Shared multiply-accumulate unit: one limb product per cycle into a column sum.
`default_nettype none
module p1305_mac_unit (
    input  wire logic        aclk,
    input  wire logic        clr,
    input  wire logic        en,
    input  wire logic [27:0] a,
    input  wire logic [28:0] b,
    output logic      [63:0] sum
);
    logic [56:0] prod_reg;
    logic        vld_reg;
    logic [63:0] sum_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= a * b;
        vld_reg  <= en;
        if (clr) begin
            sum_reg <= '0;
        end else if (vld_reg) begin
            sum_reg <= sum_reg + {7'd0, prod_reg};
        end
    end

    assign sum = sum_reg;
endmodule : p1305_mac_unit
`default_nettype wire

[hw/rtl/poly1305_mac_core.sv]
// Top level of the Poly1305 one-time authenticator core.
// Poly1305 MAC core. Message bytes arrive in transfers of up to sixteen bytes with a
// byte count and a last flag; they are moved one per cycle, pausing while a block is
// folded, into a sixteen-byte block, and every full block is folded into the 130-bit
// accumulator modulo 2^130-5 by one shared 28x29-bit multiplier, one limb product per
// cycle while a column is issued (25 products, each column followed by a drain while
// its last product is summed, then a carry pass, one limb per cycle, and a final
// fold). A transfer keeps the input stalled while its bytes are moved and while any
// block that it completes is folded; a last transfer adds a padded block if bytes
// remain, then a final reduction in the FINAL and TAG states, and the tag is offered
// on the result channel. The r half of the key is clamped inside. The key registers
// may be written only while the core is idle.
`default_nettype none
module poly1305_mac_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [63:0] s_data_low,
    input  wire logic [63:0] s_data_high,
    input  wire logic [4:0]  s_byte_count,
    input  wire logic        s_last,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [63:0] m_tag_low,
    output logic      [63:0] m_tag_high
);
    // Key registers.
    logic [63:0] rk_lo_reg, rk_hi_reg, sk_lo_reg, sk_hi_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rk_lo_reg <= '0; rk_hi_reg <= '0; sk_lo_reg <= '0; sk_hi_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                p1305_pkg::RegRLow:  rk_lo_reg <= cfg_data;
                p1305_pkg::RegRHigh: rk_hi_reg <= cfg_data;
                p1305_pkg::RegSLow:  sk_lo_reg <= cfg_data;
                p1305_pkg::RegSHigh: sk_hi_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamped r limbs and the 5*r multiples used for wrapped products.
    logic [25:0] r [5];
    logic [28:0] rs [5];
    always_comb begin
        r[0] = rk_lo_reg[25:0];
        r[1] = rk_lo_reg[51:26] & p1305_pkg::Clamp1;
        r[2] = {rk_hi_reg[13:0], rk_lo_reg[63:52]} & p1305_pkg::Clamp2;
        r[3] = rk_hi_reg[39:14] & p1305_pkg::Clamp3;
        r[4] = {2'b00, rk_hi_reg[63:40]} & p1305_pkg::Clamp4;
        for (int k = 0; k < 5; k++) begin
            rs[k] = {3'd0, r[k]} + {1'b0, r[k], 2'b00};
        end
    end

    // Holding register for the current transfer; bytes are moved one per cycle while loading.
    logic [127:0] in_data_reg;
    logic [4:0]   in_cnt_reg;
    logic         in_last_reg;
    logic [127:0] buf_reg, buf_next;
    logic [4:0]   fill_reg, fill_next;
    logic         top_reg, top_next;

    p1305_pkg::limb_t acc_reg [5];
    p1305_pkg::limb_t acc_next [5];
    // The sum of a limb and a message limb can exceed 27 bits, so h is one bit wider.
    logic [27:0] h_reg [5];
    logic [27:0] h_next [5];
    logic [63:0] col_reg [5];
    logic [63:0] col_next [5];

    p1305_pkg::state_t state_reg, state_next;
    logic [2:0] col_idx_reg, col_idx_next;   // output column, or limb in the carry pass
    logic [2:0] term_reg, term_next;         // product within column, 0..6 incl. drain
    logic [63:0] tag_lo_reg, tag_lo_next, tag_hi_reg, tag_hi_next;
    logic [37:0]  carry_reg, carry_next;
    logic [129:0] hred_reg, hred_next;

    // Operand selection for the shared multiplier: column j, term i uses h[i] and
    // r[j-i], or 5*r[5+j-i] when the index wraps.
    logic [27:0] mul_a;
    logic [28:0] mul_b;
    logic        mul_en, mul_clr;
    logic [63:0] mul_sum;
    logic [2:0]  ridx;
    always_comb begin
        mul_a = h_reg[term_reg[2:0] > 3'd4 ? 3'd4 : term_reg];
        if (col_idx_reg >= term_reg) begin
            ridx  = col_idx_reg - term_reg;
            mul_b = {3'd0, r[ridx > 3'd4 ? 3'd4 : ridx]};
        end else begin
            ridx  = col_idx_reg + 3'd5 - term_reg;
            mul_b = rs[ridx > 3'd4 ? 3'd4 : ridx];
        end
        mul_en  = (state_reg == p1305_pkg::ST_MUL) && (term_reg < 3'd5);
        // The column sum is held at zero whenever no block is being multiplied.
        mul_clr = (state_reg != p1305_pkg::ST_MUL) || (term_reg == 3'd6);
    end

    p1305_mac_unit u_mac (
        .aclk(aclk), .clr(mul_clr), .en(mul_en), .a(mul_a), .b(mul_b), .sum(mul_sum)
    );

    // Carry pass and final reduction helpers.
    logic [130:0] hsum;
    logic [130:0] gfull;
    logic [127:0] hsel;
    logic [63:0]  carry_sum;
    logic [2:0]   cidx;
    logic [31:0]  h0w;

    always_comb begin
        state_next   = state_reg;
        buf_next     = buf_reg;
        fill_next    = fill_reg;
        top_next     = top_reg;
        col_idx_next = col_idx_reg;
        term_next    = term_reg;
        tag_lo_next  = tag_lo_reg;
        tag_hi_next  = tag_hi_reg;
        carry_next   = carry_reg;
        hred_next    = hred_reg;
        for (int k = 0; k < 5; k++) begin
            acc_next[k] = acc_reg[k];
            h_next[k]   = h_reg[k];
            col_next[k] = col_reg[k];
        end
        cidx      = (col_idx_reg > 3'd4) ? 3'd4 : col_idx_reg;
        carry_sum = '0;
        h0w       = '0;
        hsum      = '0;
        gfull     = '0;
        hsel      = '0;
        s_ready = (state_reg == p1305_pkg::ST_IDLE);
        m_valid = (state_reg == p1305_pkg::ST_OUT);

        case (state_reg)
            p1305_pkg::ST_IDLE: begin
                if (s_valid) state_next = p1305_pkg::ST_LOAD;
            end
            p1305_pkg::ST_LOAD: begin
                if (in_cnt_reg != 5'd0) begin
                    buf_next[{fill_reg[3:0], 3'b000} +: 8] = in_data_reg[7:0];
                    fill_next = fill_reg + 5'd1;
                    if (fill_reg == 5'd15) begin
                        fill_next = '0;
                        top_next  = 1'b1;
                        state_next = p1305_pkg::ST_MUL;
                    end
                end else if (in_last_reg) begin
                    if (fill_reg != 5'd0) begin
                        // Pad with 0x01 then zeros, no high bit.
                        buf_next[{fill_reg[3:0], 3'b000} +: 8] = 8'h01;
                        for (int b = 0; b < 16; b++) begin
                            if (5'(b) > fill_reg) buf_next[b*8 +: 8] = 8'h00;
                        end
                        fill_next  = '0;
                        top_next   = 1'b0;
                        state_next = p1305_pkg::ST_MUL;
                    end else begin
                        state_next = p1305_pkg::ST_FINAL;
                    end
                end else begin
                    state_next = p1305_pkg::ST_IDLE;
                end
                if (state_next == p1305_pkg::ST_MUL) begin
                    h_next[0] = {1'b0, acc_reg[0]} + {2'b00, buf_next[25:0]};
                    h_next[1] = {1'b0, acc_reg[1]} + {2'b00, buf_next[51:26]};
                    h_next[2] = {1'b0, acc_reg[2]} + {2'b00, buf_next[77:52]};
                    h_next[3] = {1'b0, acc_reg[3]} + {2'b00, buf_next[103:78]};
                    h_next[4] = {1'b0, acc_reg[4]} + {3'b000, top_next, buf_next[127:104]};
                    col_idx_next = '0;
                    term_next    = '0;
                end
            end
            p1305_pkg::ST_MUL: begin
                // Terms 0..4 issue, 5 waits for the last product, 6 captures and clears.
                if (term_reg == 3'd6) begin
                    col_next[col_idx_reg] = mul_sum;
                    term_next = '0;
                    if (col_idx_reg == 3'd4) begin
                        col_idx_next = '0;
                        carry_next   = '0;
                        state_next   = p1305_pkg::ST_CARRY;
                    end else begin
                        col_idx_next = col_idx_reg + 3'd1;
                    end
                end else begin
                    term_next = term_reg + 3'd1;
                end
            end
            p1305_pkg::ST_CARRY: begin
                // Steps 0..4 carry one column each into its limb; step 5 folds the
                // carry out of the top limb back into limb 0 as a multiple of five.
                if (col_idx_reg == 3'd5) begin
                    h0w = {6'd0, acc_reg[0][25:0]} + (carry_reg[31:0] * 32'd5);
                    acc_next[0] = {1'b0, h0w[25:0]};
                    acc_next[1] = acc_reg[1] + p1305_pkg::limb_t'(h0w[31:26]);
                    state_next = (in_cnt_reg != 5'd0) ? p1305_pkg::ST_LOAD :
                                 (in_last_reg ? p1305_pkg::ST_FINAL : p1305_pkg::ST_IDLE);
                end else begin
                    carry_sum      = col_reg[cidx] + {26'd0, carry_reg};
                    acc_next[cidx] = {1'b0, carry_sum[25:0]};
                    carry_next     = carry_sum[63:26];
                    col_idx_next   = col_idx_reg + 3'd1;
                end
            end
            p1305_pkg::ST_FINAL: begin
                // The limbs are gathered into one number below 2^131, and bit 130 is
                // folded back in as five, leaving a value below 2^130.
                hsum = {acc_reg[4], 104'd0}
                     + {26'd0, acc_reg[3], 78'd0} + {52'd0, acc_reg[2], 52'd0}
                     + {78'd0, acc_reg[1], 26'd0} + {104'd0, acc_reg[0]};
                hred_next = hsum[129:0] + {127'd0, hsum[130], 1'b0, hsum[130]};
                for (int k = 0; k < 5; k++) acc_next[k] = '0;
                fill_next  = '0;
                state_next = p1305_pkg::ST_TAG;
            end
            p1305_pkg::ST_TAG: begin
                // Adding five reaches 2^130 exactly when the value is at least p,
                // and then the low 128 bits of the sum are the reduced value.
                gfull = {1'b0, hred_reg} + 131'd5;
                hsel  = gfull[130] ? gfull[127:0] : hred_reg[127:0];
                {tag_hi_next, tag_lo_next} = hsel + {sk_hi_reg, sk_lo_reg};
                state_next = p1305_pkg::ST_OUT;
            end
            p1305_pkg::ST_OUT: begin
                if (m_ready) state_next = p1305_pkg::ST_IDLE;
            end
            default: state_next = p1305_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= p1305_pkg::ST_IDLE;
            fill_reg  <= '0;
            for (int k = 0; k < 5; k++) acc_reg[k] <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            for (int k = 0; k < 5; k++) acc_reg[k] <= acc_next[k];
        end
    end

    always_ff @(posedge aclk) begin
        buf_reg     <= buf_next;
        top_reg     <= top_next;
        col_idx_reg <= col_idx_next;
        term_reg    <= term_next;
        tag_lo_reg  <= tag_lo_next;
        tag_hi_reg  <= tag_hi_next;
        carry_reg   <= carry_next;
        hred_reg    <= hred_next;
        for (int k = 0; k < 5; k++) begin
            h_reg[k]   <= h_next[k];
            col_reg[k] <= col_next[k];
        end
        if (s_valid && s_ready) begin
            in_data_reg <= {s_data_high, s_data_low};
            in_cnt_reg  <= (s_byte_count > 5'd16) ? 5'd16 : s_byte_count;
            in_last_reg <= s_last;
        end else if (state_reg == p1305_pkg::ST_LOAD && in_cnt_reg != 5'd0) begin
            in_data_reg <= {8'd0, in_data_reg[127:8]};
            in_cnt_reg  <= in_cnt_reg - 5'd1;
        end
    end

    assign m_tag_low  = tag_lo_reg;
    assign m_tag_high = tag_hi_reg;

    a_no_both: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready and result valid together");
    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg < 5'd16) else $error("fill count out of range");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_tag_low) && $stable(m_tag_high))
        else $error("result changed while stalled");
    a_acc_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> fill_reg == 5'd0 && acc_reg[0] == '0)
        else $error("state not cleared after tag");
endmodule : poly1305_mac_core
`default_nettype wire
